[rtl/lruc_pkg.sv]
// Package for the LRU set-associative cache with victim buffer.
// Holds register indexes, hit place codes and counter limits; no dependencies.
package lruc_pkg;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;
    localparam logic [1:0] REG_LINE_OFFSET = 2'd0;
    localparam logic [1:0] REG_SET_BITS    = 2'd1;
    localparam logic [1:0] REG_WAYS        = 2'd2;
    localparam logic [1:0] REG_VICTIMS     = 2'd3;
    localparam logic [1:0] PLACE_MAIN   = 2'd0;
    localparam logic [1:0] PLACE_VICTIM = 2'd1;
    localparam logic [1:0] PLACE_MISS   = 2'd2;
    localparam int COUNT_W    = 48;
    localparam int OFFSET_MAX = 12;
    localparam int ADDR_IN_W  = 48;
endpackage

[rtl/lruc_set_mem.sv]
// Set storage: one row per set holding all ways' line numbers and valid bits.
// Line numbers and valid bits in two synchronous RAMs; valid RAM cleared after reset.
// Uses lruc_pkg.
module lruc_set_mem #(
    parameter int SETS   = 64,
    parameter int WAYS   = 8,
    parameter int LINE_W = 48
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    output logic                                      clr_busy,
    input  logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] rd_set,
    output logic [WAYS-1:0][LINE_W-1:0]               rd_line,
    output logic [WAYS-1:0]                           rd_valid,
    input  logic                                      wr_en,
    input  logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] wr_set,
    input  logic [WAYS-1:0][LINE_W-1:0]               wr_line,
    input  logic [WAYS-1:0]                           wr_valid
);
    import lruc_pkg::*;
    localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;

    logic [WAYS-1:0][LINE_W-1:0] mem [SETS];
    logic [WAYS-1:0]             vmem [SETS];
    logic [SW-1:0]               clr_reg;
    logic                        clr_busy_reg;

    assign clr_busy = clr_busy_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_set] <= wr_line;
        end
        rd_line <= mem[rd_set];
    end

    // valid RAM: clearing pass has priority over write-backs
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            vmem[clr_reg] <= '0;
        end
        else if (wr_en)
        begin
            vmem[wr_set] <= wr_valid;
        end
        rd_valid <= vmem[rd_set];
    end

    // one set per cycle after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            if (clr_reg == SW'(SETS-1))
                clr_busy_reg <= 1'b0;
            else
                clr_reg <= clr_reg + SW'(1);
        end
    end
endmodule

[rtl/lru_set_assoc_cache_with_victim.sv]
// Top level of the LRU set-associative cache model with victim buffer.
// Depends on lruc_pkg and lruc_set_mem.
//
// Usage: one address transaction per access on in (valid/ready). Each access
// returns one result transaction: hit_place (0 set hit, 1 victim hit,
// 2 miss) plus saturating access and miss totals.
// Timing: the accept edge issues the set RAM read and sets the lookup stage;
// once the output register is free, the lookup compares all ways and victim
// entries, writes the reordered row back and loads the output register.
// in_ready drops while a lookup is pending and returns the cycle after it
// completes, so a new access is not taken before the last one is through.
// Back-to-back accesses cannot hit stale data: the write-back of one access
// lands before the next one's read.
// Stall: while out_ready is low the result is held and at most one more access
// is looked up; that one waits in the lookup stage until the register frees.
// Reset: counters, victim valid bits and control clear at once; the set valid
// RAM is then cleared one set per cycle with in_ready low.
// Registers: 0 line offset, 1 set index bits, 2 ways, 3 victim entries;
// the user must write them only while idle; the block does not enforce this.
module lru_set_assoc_cache_with_victim #(
    parameter int MAX_SETS         = 64,
    parameter int MAX_WAYS         = 8,
    parameter int MAX_VICTIM_LINES = 8,
    parameter int ADDRESS_BITS     = 48
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lruc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lruc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [lruc_pkg::ADDR_IN_W-1:0]    address,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        hit_place,
    output logic [lruc_pkg::COUNT_W-1:0]      access_total,
    output logic [lruc_pkg::COUNT_W-1:0]      miss_total
);
    import lruc_pkg::*;

    localparam int LW  = ADDRESS_BITS;
    localparam int SIW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WW  = $clog2(MAX_WAYS+1);
    localparam int VW  = $clog2(MAX_VICTIM_LINES+1);
    localparam int WIW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int VIW = (MAX_VICTIM_LINES > 1) ? $clog2(MAX_VICTIM_LINES) : 1;
    // largest set bit count whose set count fits in MAX_SETS
    localparam int SB_FIT = $clog2(MAX_SETS+1) - 1;
    localparam int SB_MAX = SB_FIT > 7 ? 7 : SB_FIT;
    localparam logic [COUNT_W-1:0] CNT_MAX = '1;

    // configuration
    logic [3:0] off_reg;
    logic [2:0] sbits_reg;
    logic [3:0] ways_reg;
    logic [3:0] vics_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg   <= 4'd6;
            sbits_reg <= 3'd6;
            ways_reg  <= 4'd8;
            vics_reg  <= 4'd4;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LINE_OFFSET: off_reg   <= cfg_data;
                REG_SET_BITS:    sbits_reg <= cfg_data[2:0];
                REG_WAYS:        ways_reg  <= cfg_data;
                REG_VICTIMS:     vics_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // effective sizes
    logic [3:0]     eff_off;
    logic [2:0]     eff_sb;
    logic [WW-1:0]  eff_ways;
    logic [VW-1:0]  eff_vics;

    always_comb
    begin
        eff_off = (off_reg > 4'(OFFSET_MAX)) ? 4'(OFFSET_MAX) : off_reg;
        eff_sb  = (int'(sbits_reg) > SB_MAX) ? 3'(SB_MAX) : sbits_reg;
        if (ways_reg == 4'd0)
            eff_ways = WW'(1);
        else if (int'(ways_reg) > MAX_WAYS)
            eff_ways = WW'(MAX_WAYS);
        else
            eff_ways = WW'(ways_reg);
        if (int'(vics_reg) > MAX_VICTIM_LINES)
            eff_vics = VW'(MAX_VICTIM_LINES);
        else
            eff_vics = VW'(vics_reg);
    end

    // stage 1: address decode, RAM read issued
    logic [LW-1:0]  line_in;
    logic [SIW-1:0] set_in;
    logic           look_reg;
    logic [LW-1:0]  line_reg;
    logic [SIW-1:0] set_reg;
    logic           adv;       // lookup completes this cycle
    logic           out_free;
    logic           mem_busy;  // valid RAM clearing pass after reset

    assign line_in  = LW'(LW'(address) >> eff_off);
    assign set_in   = SIW'(line_in & ((LW'(1) << eff_sb) - LW'(1)));
    assign out_free = !out_valid || out_ready;
    assign adv      = look_reg && out_free;
    assign in_ready = !look_reg && !mem_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            look_reg <= 1'b0;
        else if (in_valid && in_ready)
            look_reg <= 1'b1;
        else if (adv)
            look_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            line_reg <= line_in;
            set_reg  <= set_in;
        end
    end

    logic [MAX_WAYS-1:0][LW-1:0] row_line;
    logic [MAX_WAYS-1:0]         row_valid;
    logic [MAX_WAYS-1:0][LW-1:0] wb_line;
    logic [MAX_WAYS-1:0]         wb_valid;
    logic                        row_hold_reg;
    logic [MAX_WAYS-1:0][LW-1:0] hold_line_reg;
    logic [MAX_WAYS-1:0]         hold_valid_reg;
    logic [MAX_WAYS-1:0][LW-1:0] cur_line;
    logic [MAX_WAYS-1:0]         cur_valid;

    lruc_set_mem #(.SETS(MAX_SETS), .WAYS(MAX_WAYS), .LINE_W(LW)) u_set_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr_busy (mem_busy),
        .rd_set   (set_in),
        .rd_line  (row_line),
        .rd_valid (row_valid),
        .wr_en    (adv),
        .wr_set   (set_reg),
        .wr_line  (wb_line),
        .wr_valid (wb_valid)
    );

    // hold the read row while the lookup stalls on the output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_hold_reg <= 1'b0;
        else
            row_hold_reg <= look_reg && !out_free;
    end

    always_ff @(posedge clk)
    begin
        if (look_reg && !out_free)
        begin
            hold_line_reg  <= cur_line;
            hold_valid_reg <= cur_valid;
        end
    end

    assign cur_line  = row_hold_reg ? hold_line_reg  : row_line;
    assign cur_valid = row_hold_reg ? hold_valid_reg : row_valid;

    // victim buffer (small, flops)
    logic [MAX_VICTIM_LINES-1:0][LW-1:0] vic_line_reg;
    logic [MAX_VICTIM_LINES-1:0]         vic_valid_reg;
    logic [MAX_VICTIM_LINES-1:0][LW-1:0] vic_line_next;
    logic [MAX_VICTIM_LINES-1:0]         vic_valid_next;

    // stage 2: compare and reorder
    logic           s_found, v_found;
    logic [WIW-1:0] s_pos;
    logic [VIW-1:0] v_pos;
    logic [WW-1:0]  s_top;
    logic [VW-1:0]  v_top;
    logic [LW-1:0]  old_num;
    logic           old_val;
    logic           v_ins;
    logic [LW-1:0]  v_num;
    logic           v_val;
    logic [1:0]     place;

    always_comb
    begin
        s_found = 1'b0;
        s_pos   = '0;
        for (int i = MAX_WAYS-1; i >= 0; i--)
        begin
            if (i < int'(eff_ways) && cur_valid[i] && cur_line[i] == line_reg)
            begin
                s_found = 1'b1;
                s_pos   = WIW'(i);
            end
        end
        v_found = 1'b0;
        v_pos   = '0;
        for (int v = MAX_VICTIM_LINES-1; v >= 0; v--)
        begin
            if (v < int'(eff_vics) && vic_valid_reg[v] && vic_line_reg[v] == line_reg)
            begin
                v_found = 1'b1;
                v_pos   = VIW'(v);
            end
        end
        old_num = cur_line[WIW'(eff_ways - WW'(1))];
        old_val = cur_valid[WIW'(eff_ways - WW'(1))];
        s_top   = s_found ? WW'(s_pos) : (eff_ways - WW'(1));

        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (i == 0)
            begin
                wb_line[i]  = line_reg;
                wb_valid[i] = 1'b1;
            end
            else if (i <= int'(s_top))
            begin
                wb_line[i]  = cur_line[i-1];
                wb_valid[i] = cur_valid[i-1];
            end
            else
            begin
                wb_line[i]  = cur_line[i];
                wb_valid[i] = cur_valid[i];
            end
        end

        v_ins = 1'b0;
        v_num = old_num;
        v_val = old_val;
        v_top = '0;
        if (!s_found)
        begin
            if (v_found)
            begin
                v_ins = 1'b1;
                v_top = VW'(v_pos);
            end
            else if (eff_vics != '0 && old_val)
            begin
                v_ins = 1'b1;
                v_top = eff_vics - VW'(1);
            end
        end
        for (int v = 0; v < MAX_VICTIM_LINES; v++)
        begin
            if (v_ins && v == 0)
            begin
                vic_line_next[v]  = v_num;
                vic_valid_next[v] = v_val;
            end
            else if (v_ins && v <= int'(v_top))
            begin
                vic_line_next[v]  = vic_line_reg[v-1];
                vic_valid_next[v] = vic_valid_reg[v-1];
            end
            else
            begin
                vic_line_next[v]  = vic_line_reg[v];
                vic_valid_next[v] = vic_valid_reg[v];
            end
        end
        place = s_found ? PLACE_MAIN : (v_found ? PLACE_VICTIM : PLACE_MISS);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            vic_line_reg <= vic_line_next;
    end

    // counters and output register
    logic [COUNT_W-1:0] acc_reg, acc_next;
    logic [COUNT_W-1:0] miss_reg, miss_next;

    assign acc_next  = (acc_reg == CNT_MAX) ? acc_reg : acc_reg + COUNT_W'(1);
    assign miss_next = (place == PLACE_MISS && miss_reg != CNT_MAX)
                       ? miss_reg + COUNT_W'(1) : miss_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vic_valid_reg <= '0;
            acc_reg       <= '0;
            miss_reg      <= '0;
            out_valid     <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                vic_valid_reg <= vic_valid_next;
                acc_reg       <= acc_next;
                miss_reg      <= miss_next;
                out_valid     <= 1'b1;
            end
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            hit_place <= place;
    end

    assign access_total = acc_reg;
    assign miss_total   = miss_reg;

`ifndef SYNTHESIS
    a_miss_le_acc: assert property (@(posedge clk) disable iff (!rst_n)
        miss_reg <= acc_reg) else $error("miss count above access count");
    a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_valid) else $error("result not presented");
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        look_reg |-> !in_ready) else $error("second lookup accepted");
    a_acc_step: assert property (@(posedge clk) disable iff (!rst_n)
        adv && acc_reg != CNT_MAX |=> acc_reg == $past(acc_reg) + COUNT_W'(1))
        else $error("access count did not advance");
`endif
endmodule

[tb/lru_set_assoc_cache_with_victim_test.sv]
// Self-checking testbench for lru_set_assoc_cache_with_victim.
// Depends on lruc_pkg and the cache RTL; predicts each lookup with its own LRU model.
`timescale 1ns / 1ps

module lru_set_assoc_cache_with_victim_test;
    import lruc_pkg::*;

    localparam int N_SETS    = 64;
    localparam int N_WAYS    = 8;
    localparam int N_VICTIMS = 8;
    localparam logic [47:0] COUNT_TOP = 48'hFFFF_FFFF_FFFF;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]  place;
        logic [47:0] accesses;
        logic [47:0] misses;
    } lookup_result_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [47:0] address;
    logic out_valid;
    logic out_ready;
    logic [1:0] hit_place;
    logic [47:0] access_total;
    logic [47:0] miss_total;

    lru_set_assoc_cache_with_victim dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .address(address),
        .out_valid(out_valid), .out_ready(out_ready),
        .hit_place(hit_place), .access_total(access_total), .miss_total(miss_total)
    );

    // Shadow copy of the cache: tags, valid bits, counters and registers.
    logic [47:0] shadow_tag [N_SETS*N_WAYS];
    logic        shadow_vld [N_SETS*N_WAYS];
    logic [47:0] victim_tag [N_VICTIMS];
    logic        victim_vld [N_VICTIMS];
    logic [47:0] access_cnt;
    logic [47:0] miss_cnt;
    logic [3:0]  reg_offset;
    logic [2:0]  reg_set_bits;
    logic [3:0]  reg_ways;
    logic [3:0]  reg_victims;

    logic [47:0]    address_queue[$];   // addresses waiting for the driver
    lookup_result_t expected_results[$];
    int  error_count;
    int  results_seen;
    int  cycle_count;
    bit  idle_enable;                   // random idling on both sides

    // Computes one lookup and updates the shadow cache, LRU order included.
    function automatic lookup_result_t predict_lookup(logic [47:0] addr);
        int off, sb, nw, nv, base, hit_way, hit_vic, k;
        logic [47:0] line;
        logic [47:0] old_tag;
        logic        old_vld;
        lookup_result_t r;
        off = (reg_offset > OFFSET_MAX) ? OFFSET_MAX : reg_offset;
        sb = reg_set_bits;
        while (sb > 0 && (1 << sb) > N_SETS) sb--;
        nw = (reg_ways == 0) ? 1 : ((reg_ways > N_WAYS) ? N_WAYS : reg_ways);
        nv = (reg_victims > N_VICTIMS) ? N_VICTIMS : reg_victims;
        line = addr >> off;
        base = int'(line & ((48'd1 << sb) - 1)) * N_WAYS;
        hit_way = -1;
        hit_vic = -1;
        r.place = PLACE_MISS;
        for (k = 0; k < nw; k++)
            if (hit_way < 0 && shadow_vld[base+k] && shadow_tag[base+k] == line)
                hit_way = k;
        if (hit_way >= 0) begin
            for (k = hit_way; k > 0; k--) begin
                shadow_tag[base+k] = shadow_tag[base+k-1];
                shadow_vld[base+k] = shadow_vld[base+k-1];
            end
            r.place = PLACE_MAIN;
        end else begin
            old_tag = shadow_tag[base+nw-1];
            old_vld = shadow_vld[base+nw-1];
            for (k = 0; k < nv; k++)
                if (hit_vic < 0 && victim_vld[k] && victim_tag[k] == line)
                    hit_vic = k;
            for (k = nw - 1; k > 0; k--) begin
                shadow_tag[base+k] = shadow_tag[base+k-1];
                shadow_vld[base+k] = shadow_vld[base+k-1];
            end
            if (hit_vic >= 0) begin
                // swap: set's oldest line goes to the victim front, even if empty
                for (k = hit_vic; k > 0; k--) begin
                    victim_tag[k] = victim_tag[k-1];
                    victim_vld[k] = victim_vld[k-1];
                end
                victim_tag[0] = old_tag;
                victim_vld[0] = old_vld;
                r.place = PLACE_VICTIM;
            end else if (nv > 0 && old_vld) begin
                for (k = nv - 1; k > 0; k--) begin
                    victim_tag[k] = victim_tag[k-1];
                    victim_vld[k] = victim_vld[k-1];
                end
                victim_tag[0] = old_tag;
                victim_vld[0] = 1'b1;
            end
        end
        shadow_tag[base] = line;
        shadow_vld[base] = 1'b1;
        if (access_cnt != COUNT_TOP) access_cnt++;
        if (r.place == PLACE_MISS && miss_cnt != COUNT_TOP) miss_cnt++;
        r.accesses = access_cnt;
        r.misses = miss_cnt;
        return r;
    endfunction

    // 12 ns clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Driver: takes addresses off the queue; valid holds until accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            address <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (address_queue.size() > 0 && !(idle_enable && $urandom_range(99) < 14))
            begin
                in_valid <= 1'b1;
                address <= address_queue.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Predict on each accepted address transaction.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            expected_results.push_back(predict_lookup(address));
    end

    // Monitor: random backpressure and field-by-field compare.
    always @(posedge clk or negedge rst_n)
    begin
        lookup_result_t exp_r;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            out_ready <= !(idle_enable && $urandom_range(99) < 14);
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    error_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (hit_place !== exp_r.place)
                    begin
                        $error("hit_place expected %0d actual %0d", exp_r.place, hit_place);
                        error_count++;
                    end
                    if (access_total !== exp_r.accesses)
                    begin
                        $error("access_total expected %0d actual %0d",
                               exp_r.accesses, access_total);
                        error_count++;
                    end
                    if (miss_total !== exp_r.misses)
                    begin
                        $error("miss_total expected %0d actual %0d", exp_r.misses, miss_total);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Register write at an idle point; the shadow copy follows.
    task automatic write_reg(logic [1:0] idx, logic [3:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_LINE_OFFSET: reg_offset = val;
            REG_SET_BITS:    reg_set_bits = val[2:0];
            REG_WAYS:        reg_ways = val;
            REG_VICTIMS:     reg_victims = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (address_queue.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Random addresses with heavy reuse from a small pool so hits and
    // victim hits happen; a few fully random addresses for bit coverage.
    task automatic queue_random(int count, int pool_size);
        logic [47:0] pool[$];
        logic [47:0] a;
        int k;
        for (k = 0; k < pool_size; k++)
            pool.push_back(48'({$urandom(), $urandom()}));
        for (k = 0; k < count; k++)
        begin
            if ($urandom_range(9) == 0)
                a = 48'({$urandom(), $urandom()});
            else
                a = pool[$urandom_range(pool_size - 1)] ^ 48'($urandom_range(63));
            address_queue.push_back(a);
        end
    endtask

    initial
    begin
        int k;
        for (k = 0; k < N_SETS*N_WAYS; k++)
        begin
            shadow_tag[k] = '0;
            shadow_vld[k] = 1'b0;
        end
        for (k = 0; k < N_VICTIMS; k++)
        begin
            victim_tag[k] = '0;
            victim_vld[k] = 1'b0;
        end
        access_cnt = '0;
        miss_cnt = '0;
        reg_offset = 4'd6;
        reg_set_bits = 3'd6;
        reg_ways = 4'd8;
        reg_victims = 4'd4;
        error_count = 0;
        results_seen = 0;
        cycle_count = 0;
        idle_enable = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: address zero on empty cache, extremes, hit, then one
        // direct-mapped set with a 1-entry victim to force swaps.
        address_queue.push_back(48'h0);
        address_queue.push_back(48'h0);
        address_queue.push_back(48'hFFFF_FFFF_FFFF);
        address_queue.push_back(48'hFFFF_FFFF_FFFF);
        address_queue.push_back(48'h0000_0000_003F);
        drain();
        write_reg(REG_SET_BITS, 4'd0);
        write_reg(REG_WAYS, 4'd0);       // zero ways acts as one
        write_reg(REG_VICTIMS, 4'd1);
        write_reg(REG_LINE_OFFSET, 4'd15); // clamps to 12
        address_queue.push_back(48'h1000);
        address_queue.push_back(48'h2000);   // pushes 0x1000 line into victim
        address_queue.push_back(48'h1000);   // victim hit, swap
        address_queue.push_back(48'h2000);   // victim hit again
        address_queue.push_back(48'h3000);   // full miss, drops oldest victim
        address_queue.push_back(48'hAAAA_AAAA_A000);
        address_queue.push_back(48'h5555_5555_5000);
        drain();
        write_reg(REG_SET_BITS, 4'd7);   // more sets than exist: clamps
        write_reg(REG_WAYS, 4'd15);      // clamps to 8
        write_reg(REG_VICTIMS, 4'd15);   // clamps to 8
        write_reg(REG_LINE_OFFSET, 4'd0);
        for (k = 0; k < 12; k++)
            address_queue.push_back(48'(k) << 6);
        drain();

        // Random phases over several settings; first one without idling.
        write_reg(REG_LINE_OFFSET, 4'd6);
        write_reg(REG_SET_BITS, 4'd2);
        write_reg(REG_WAYS, 4'd2);
        write_reg(REG_VICTIMS, 4'd0);    // no victim cache
        queue_random(80, 16);
        drain();
        idle_enable = 1'b1;
        write_reg(REG_VICTIMS, 4'd3);
        write_reg(REG_WAYS, 4'd4);
        queue_random(100, 24);
        drain();
        write_reg(REG_LINE_OFFSET, 4'd12);
        write_reg(REG_SET_BITS, 4'd6);
        write_reg(REG_WAYS, 4'd8);
        write_reg(REG_VICTIMS, 4'd8);
        queue_random(100, 40);
        drain();
        write_reg(REG_LINE_OFFSET, 4'd3);
        write_reg(REG_SET_BITS, 4'd1);
        write_reg(REG_WAYS, 4'd1);
        write_reg(REG_VICTIMS, 4'd2);    // shrunken sizes keep old entries
        queue_random(100, 10);
        drain();

        $display("covered %0d lookups under clamped, minimal and maximal settings", results_seen);
        $display("victim cache off, small and full; random idling on both sides");
        if (error_count == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
